// ----- src/priority_round_robin_scheduler_unit_defines.svh -----
// assertion macros for the scheduler checker
`ifndef PRIORITY_ROUND_ROBIN_SCHEDULER_UNIT_DEFINES_SVH
`define PRIORITY_ROUND_ROBIN_SCHEDULER_UNIT_DEFINES_SVH
// implication checked on every clock edge outside reset
`define PRRS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define PRRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ----- src/prrs_pkg.sv -----
//------------------------------------------------------------------------------
// prrs_pkg
// shared types and constants of the priority round-robin scheduler
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package prrs_pkg;
   localparam int LEVELS = 16;
   localparam int JOBS = 64;
   localparam int LVL_W = $clog2(LEVELS);
   localparam int SLOT_W = $clog2(JOBS);
   localparam int CNT_W = $clog2(JOBS + 1);
   localparam logic [15:0] QUANTUM_RESET = 16'd10;

   localparam logic [1:0] ST_ADDED = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_SLICE = 2'd2;
   localparam logic [1:0] ST_IDLE = 2'd3;

   localparam logic KIND_ADD = 1'b0;
   localparam logic KIND_DISPATCH = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [31:0] tag;
      logic [3:0]  prio;
      logic [15:0] burst;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] tag;
      logic [3:0]  prio;
      logic [15:0] burst;
      logic [15:0] slice;
      logic [15:0] remaining;
      logic        completed;
      logic [31:0] elapsed;
   } rsp_type;
endpackage
`default_nettype wire

// ----- src/prrs_front.sv -----
//------------------------------------------------------------------------------
// prrs_front
// accepts request beats, saturates the level and queues commands
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module prrs_front import prrs_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic        req_kind,
   input  wire logic [31:0] req_job_tag,
   input  wire logic [3:0]  req_priority_req,
   input  wire logic [15:0] req_burst,
   output logic             cmd_valid,
   output cmd_type          cmd,
   input  wire logic        cmd_take
);
   // two-entry queue
   cmd_type    q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in;
   logic       wr_ff, wr_in;
   cmd_type    c;
   logic       do_push, do_pop;

   always_comb begin
      c.kind = req_kind;
      c.tag = req_job_tag;
      c.burst = req_burst;
      if ({28'd0, req_priority_req} >= LEVELS) begin
         c.prio = 4'(LEVELS - 1);
      end else begin
         c.prio = req_priority_req;
      end
   end

   assign full = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = q_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop = cmd_take && cmd_valid;
   assign cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   assign rd_in = rd_ff ^ do_pop;
   assign wr_in = wr_ff ^ do_push;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
      end
      if (do_push) begin
         q_ff[wr_ff] <= c;
      end
   end
endmodule
`default_nettype wire

// ----- src/prrs_back.sv -----
//------------------------------------------------------------------------------
// prrs_back
// sequencer over job, link and free-slot memories, one command at a time
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module prrs_back import prrs_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [15:0] quantum,
   input  wire logic        cmd_valid,
   input  wire cmd_type     cmd,
   output logic             cmd_take,
   output logic             rsp_valid,
   output rsp_type          rsp,
   input  wire logic        rsp_take
);
   typedef enum logic [2:0] {S_IDLE, S_ADD, S_DRD, S_DEX, S_OUT} state_type;

   state_type state_ff;
   logic [63:0] job_mem [JOBS];
   logic [SLOT_W-1:0] link_mem [JOBS];
   logic [SLOT_W-1:0] free_mem [JOBS];
   logic [SLOT_W-1:0] head_ff [LEVELS];
   logic [SLOT_W-1:0] tail_ff [LEVELS];
   logic [LEVELS-1:0] nonempty_ff;
   logic [CNT_W-1:0] free_cnt_ff;
   logic [SLOT_W-1:0] init_ff;
   logic init_done_ff;
   logic [31:0] elapsed_ff;
   cmd_type cmd_ff;
   logic [LVL_W-1:0] lvl_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [63:0] job_rd_ff;
   logic [SLOT_W-1:0] link_rd_ff;
   logic [SLOT_W-1:0] free_rd_ff;
   rsp_type rsp_ff;

   logic [LVL_W-1:0] top_lvl;
   logic [15:0] q_eff, rem_cur, slice_v, rem_new;
   logic [CNT_W-1:0] fc_dec;
   logic is_single;
   rsp_type rsp_start;

   always_comb begin
      top_lvl = '0;
      for (int l = 0; l < LEVELS; l++) begin
         if (nonempty_ff[l]) top_lvl = LVL_W'(l);
      end
   end

   // first view of a dispatch result: idle or slice, current elapsed time
   always_comb begin
      rsp_start = '0;
      rsp_start.status = (nonempty_ff == '0) ? ST_IDLE : ST_SLICE;
      rsp_start.elapsed = elapsed_ff;
   end

   assign q_eff = (quantum == 16'd0) ? 16'd1 : quantum;
   assign rem_cur = job_rd_ff[15:0];
   assign slice_v = (rem_cur < q_eff) ? rem_cur : q_eff;
   assign rem_new = rem_cur - slice_v;
   assign fc_dec = free_cnt_ff - CNT_W'(1);
   assign is_single = (head_ff[lvl_ff] == tail_ff[lvl_ff]);
   assign cmd_take = (state_ff == S_IDLE) && init_done_ff;
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         nonempty_ff <= '0;
         free_cnt_ff <= CNT_W'(JOBS);
         elapsed_ff <= '0;
         init_ff <= '0;
         init_done_ff <= 1'b0;
      end else begin
         // fill the free-slot stack after reset
         if (!init_done_ff) begin
            free_mem[init_ff] <= init_ff;
            init_ff <= init_ff + SLOT_W'(1);
            if (init_ff == SLOT_W'(JOBS - 1)) init_done_ff <= 1'b1;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_valid && init_done_ff) begin
                  cmd_ff <= cmd;
                  if (cmd.kind == KIND_ADD) begin
                     rsp_ff <= '0;
                     lvl_ff <= cmd.prio[LVL_W-1:0];
                     free_rd_ff <= free_mem[free_cnt_ff[SLOT_W-1:0] - SLOT_W'(1)];
                     state_ff <= S_ADD;
                  end else begin
                     rsp_ff <= rsp_start;
                     lvl_ff <= top_lvl;
                     slot_ff <= head_ff[top_lvl];
                     state_ff <= (nonempty_ff == '0) ? S_OUT : S_DRD;
                  end
               end
            end
            S_ADD: begin
               rsp_ff.elapsed <= elapsed_ff;
               if (free_cnt_ff == '0) begin
                  rsp_ff.status <= ST_FULL;
               end else begin
                  rsp_ff.status <= ST_ADDED;
                  free_cnt_ff <= fc_dec;
                  job_mem[free_rd_ff] <= {cmd_ff.tag, cmd_ff.burst, cmd_ff.burst};
                  if (nonempty_ff[lvl_ff]) begin
                     link_mem[tail_ff[lvl_ff]] <= free_rd_ff;
                  end else begin
                     head_ff[lvl_ff] <= free_rd_ff;
                     nonempty_ff[lvl_ff] <= 1'b1;
                  end
                  tail_ff[lvl_ff] <= free_rd_ff;
               end
               state_ff <= S_OUT;
            end
            S_DRD: begin
               job_rd_ff <= job_mem[slot_ff];
               link_rd_ff <= link_mem[slot_ff];
               state_ff <= S_DEX;
            end
            S_DEX: begin
               job_mem[slot_ff] <= {job_rd_ff[63:16], rem_new};
               elapsed_ff <= elapsed_ff + {16'd0, slice_v};
               rsp_ff.tag <= job_rd_ff[63:32];
               rsp_ff.prio <= 4'(lvl_ff);
               rsp_ff.burst <= job_rd_ff[31:16];
               rsp_ff.slice <= slice_v;
               rsp_ff.remaining <= rem_new;
               rsp_ff.completed <= (rem_new == 16'd0);
               rsp_ff.elapsed <= elapsed_ff + {16'd0, slice_v};
               if (rem_new == 16'd0) begin
                  if (is_single) nonempty_ff[lvl_ff] <= 1'b0;
                  else head_ff[lvl_ff] <= link_rd_ff;
                  if (free_cnt_ff < CNT_W'(JOBS)) begin
                     free_mem[free_cnt_ff[SLOT_W-1:0]] <= slot_ff;
                     free_cnt_ff <= free_cnt_ff + CNT_W'(1);
                  end
               end else if (!is_single) begin
                  head_ff[lvl_ff] <= link_rd_ff;
                  link_mem[tail_ff[lvl_ff]] <= slot_ff;
                  tail_ff[lvl_ff] <= slot_ff;
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (rsp_take) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ----- src/priority_round_robin_scheduler_unit.sv -----
// add: slot allocation and ring link, then result; dispatch: read, then update, then
//   result (straight to the result when no job is queued); the back-end sequencer walks
//   the job and link memories for one item at a time and takes no new command until popped
// reset: synchronous; after reset a sweep fills the free-slot stack,
//   requests queue in the front but none is carried out until it ends
// quantum resets to 10
//------------------------------------------------------------------------------
// priority_round_robin_scheduler_unit
// per-level job rings with round-robin slices, highest level first
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module priority_round_robin_scheduler_unit import prrs_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   // request beats
   input  wire logic        push,
   output logic             full,
   input  wire logic        req_kind,
   input  wire logic [31:0] req_job_tag,
   input  wire logic [3:0]  req_priority_req,
   input  wire logic [15:0] req_burst,
   // result beats
   output logic             empty,
   input  wire logic        pop,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_job_tag_out,
   output logic [3:0]       rsp_priority_out,
   output logic [15:0]      rsp_burst_out,
   output logic [15:0]      rsp_slice_time,
   output logic [15:0]      rsp_remaining_time,
   output logic             rsp_completed,
   output logic [31:0]      rsp_elapsed_time,
   // quantum register write
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);
   logic [15:0] quantum_ff;
   logic        cmd_valid, cmd_take, rsp_valid;
   cmd_type     cmd;
   rsp_type     rsp;

   // quantum register, always writable
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= QUANTUM_RESET;
      end else if (csr_valid) begin
         quantum_ff <= csr_data;
      end
   end

   // front: command queue
   prrs_front u_front (
      .clock, .reset, .push, .full,
      .req_kind, .req_job_tag, .req_priority_req, .req_burst,
      .cmd_valid, .cmd, .cmd_take
   );

   // back: memory sequencer, result held until popped
   prrs_back u_back (
      .clock, .reset, .quantum(quantum_ff),
      .cmd_valid, .cmd, .cmd_take,
      .rsp_valid, .rsp, .rsp_take(pop)
   );

   assign empty = !rsp_valid;
   assign rsp_status = rsp.status;
   assign rsp_job_tag_out = rsp.tag;
   assign rsp_priority_out = rsp.prio;
   assign rsp_burst_out = rsp.burst;
   assign rsp_slice_time = rsp.slice;
   assign rsp_remaining_time = rsp.remaining;
   assign rsp_completed = rsp.completed;
   assign rsp_elapsed_time = rsp.elapsed;
endmodule
`default_nettype wire

// ----- src/prrs_checker.sv -----
//------------------------------------------------------------------------------
// prrs_checker
// port-level checks of the scheduler
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "priority_round_robin_scheduler_unit_defines.svh"
module prrs_checker import prrs_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        empty,
   input wire logic        pop,
   input wire logic [1:0]  rsp_status,
   input wire logic [15:0] rsp_slice_time,
   input wire logic [15:0] rsp_remaining_time,
   input wire logic        rsp_completed,
   input wire logic [31:0] rsp_elapsed_time
);
   `PRRS_ASSERT_IMPL(a_done_rem, clock, reset, !empty && rsp_status == ST_SLICE, rsp_completed == (rsp_remaining_time == 16'd0))
   `PRRS_ASSERT_IMPL(a_noslice, clock, reset, !empty && rsp_status != ST_SLICE, rsp_slice_time == 16'd0 && !rsp_completed)
   `PRRS_ASSERT_NEXT(a_hold, clock, reset, !empty && !pop, !empty && $stable(rsp_elapsed_time))
endmodule
bind priority_round_robin_scheduler_unit prrs_checker u_prrs_checker (
   .clock, .reset, .empty, .pop, .rsp_status, .rsp_slice_time,
   .rsp_remaining_time, .rsp_completed, .rsp_elapsed_time
);
`default_nettype wire
